// File: rtl/cct_dimming_compensation_macros.svh
// Assertion macros for the CCT dimming compensation block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef CCT_DIMMING_COMPENSATION_MACROS_SVH
`define CCT_DIMMING_COMPENSATION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CCT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CCT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/cct_pkg.sv
// Shared types, codes, tables and constant dividers for CCT dimming compensation.
// No dependencies; used by cct_comp_chan and cct_dimming_compensation.
package cct_pkg;

    localparam int PULSE_FULL_SCALE_DEF = 2000;
    localparam int OUT_MAX = 2047;
    localparam int NSTAGE = 7;
    localparam int ROWS = 15;

    // compensation modes
    localparam logic [2:0] MODE_NONE  = 3'd0;
    localparam logic [2:0] MODE_PCT   = 3'd1;
    localparam logic [2:0] MODE_LIN   = 3'd2;
    localparam logic [2:0] MODE_QUAD  = 3'd3;
    localparam logic [2:0] MODE_CUBIC = 3'd4;
    localparam logic [2:0] MODE_TABLE = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_MODE      = 2'd0;
    localparam logic [1:0] REG_COLD_WATT = 2'd1;
    localparam logic [1:0] REG_WARM_WATT = 2'd2;

    typedef logic [ROWS-1:0][6:0] pct_table_t;
    typedef logic [ROWS-1:0][3:0] add_table_t;

    typedef struct packed {
        logic [NSTAGE-1:0] adv;
    } pipe_ctl_t;

    // row 0 in the lowest slot
    localparam pct_table_t ROW_PCT = {7'd100, 7'd96, 7'd93, 7'd90, 7'd80, 7'd70, 7'd60,
                                      7'd50, 7'd40, 7'd30, 7'd20, 7'd10, 7'd8, 7'd5, 7'd0};
    localparam add_table_t COLD_ADD = {4'd0, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd8,
                                       4'd10, 4'd8, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd0};
    localparam add_table_t WARM_ADD = {4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd8, 4'd9,
                                       4'd10, 4'd8, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd0};

    // Reciprocal multipliers, exact over the full input width of each function.
    localparam logic [13:0] RECIP_100 = 14'd10486; // 2^20 / 100, rounded up
    localparam logic [13:0] RECIP_60  = 14'd8739;  // 2^19 / 60, rounded up
    localparam logic [12:0] RECIP_50  = 13'd5243;  // 2^18 / 50, rounded up

    function automatic logic [7:0] div100(input logic [13:0] x);
        logic [27:0] prod;
        prod = 28'(x) * 28'(RECIP_100);
        return prod[27:20];
    endfunction

    function automatic logic [7:0] div60(input logic [12:0] x);
        logic [26:0] prod;
        prod = 27'(x) * 27'(RECIP_60);
        return prod[26:19];
    endfunction

    function automatic logic [7:0] div50(input logic [12:0] x);
        logic [25:0] prod;
        prod = 26'(x) * 26'(RECIP_50);
        return prod[25:18];
    endfunction

endpackage

// File: rtl/cct_comp_chan.sv
// One channel of the compensation datapath: seven register stages from
// percentage to PWM compare value. Depends on cct_pkg; stage enables come from the top.
module cct_comp_chan #(
    parameter int PULSE_FULL_SCALE = cct_pkg::PULSE_FULL_SCALE_DEF
) (
    input  logic                clk,
    input  cct_pkg::pipe_ctl_t  ctl,
    input  logic [2:0]          mode,
    input  logic [6:0]          watt,
    input  cct_pkg::add_table_t adds,
    input  logic [7:0]          pct,
    output logic [10:0]         pulse_width
);

    localparam int SCALE = PULSE_FULL_SCALE / 100;
    localparam int PROD_W = $clog2(255 * SCALE + 1);
    localparam int LIMIT = (PULSE_FULL_SCALE < cct_pkg::OUT_MAX) ?
                           PULSE_FULL_SCALE : cct_pkg::OUT_MAX;

    // stage 1
    logic [6:0]  p_c, w_c, d1_next;
    logic [5:0]  t1_next;
    logic [13:0] pw1_next;
    logic [12:0] td1_next;
    logic [11:0] tt1_next;
    logic [6:0]  p1_reg, d1_reg;
    logic [5:0]  t1_reg;
    logic [13:0] pw1_reg;
    logic [12:0] td1_reg;
    logic [11:0] tt1_reg;
    // stage 2
    logic [6:0]  base2_next, lin2_next;
    logic [5:0]  tt50_2_next;
    logic [3:0]  add2_next;
    logic [6:0]  p2_reg, d2_reg, base2_reg, lin2_reg;
    logic [5:0]  t2_reg, tt50_2_reg;
    logic [3:0]  add2_reg;
    // stage 3
    logic [12:0] q1_3_next;
    logic [6:0]  p3_reg, base3_reg, lin3_reg;
    logic [5:0]  t3_reg;
    logic [3:0]  add3_reg;
    logic [12:0] q1_3_reg;
    // stage 4
    logic [6:0]  q2_4_next;
    logic [6:0]  p4_reg, base4_reg, lin4_reg, q2_4_reg;
    logic [5:0]  t4_reg;
    logic [3:0]  add4_reg;
    // stage 5
    logic [12:0] c3m_5_next;
    logic [6:0]  p5_reg, base5_reg, lin5_reg, q2_5_reg;
    logic [3:0]  add5_reg;
    logic [12:0] c3m_5_reg;
    // stage 6
    logic [7:0]  comp6_next, comp6_reg;
    // stage 7
    logic [PROD_W-1:0] prod7;
    logic [10:0] pulse7_next, pulse7_reg;

    always_comb
    begin
        p_c = (pct > 8'd100) ? 7'd100 : pct[6:0];
        w_c = (watt > 7'd100) ? 7'd100 : watt;
        t1_next = (p_c > 7'd50) ? 6'(7'd100 - p_c) : p_c[5:0];
        d1_next = 7'd100 - w_c;
        pw1_next = 14'(p_c) * 14'(w_c);
        td1_next = 13'(t1_next) * 13'(d1_next);
        tt1_next = 12'(t1_next) * 12'(t1_next);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv[0])
        begin
            p1_reg  <= p_c;
            t1_reg  <= t1_next;
            d1_reg  <= d1_next;
            pw1_reg <= pw1_next;
            td1_reg <= td1_next;
            tt1_reg <= tt1_next;
        end
    end

    always_comb
    begin
        base2_next = 7'(cct_pkg::div100(pw1_reg));
        lin2_next = 7'(cct_pkg::div60(td1_reg));
        tt50_2_next = 6'(cct_pkg::div50(13'(tt1_reg)));
        // first row whose percent is at or above p wins
        add2_next = 4'd0;
        for (int i = cct_pkg::ROWS - 1; i >= 0; i--)
        begin
            if (p1_reg <= cct_pkg::ROW_PCT[i])
                add2_next = adds[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv[1])
        begin
            p2_reg     <= p1_reg;
            t2_reg     <= t1_reg;
            d2_reg     <= d1_reg;
            base2_reg  <= base2_next;
            lin2_reg   <= lin2_next;
            tt50_2_reg <= tt50_2_next;
            add2_reg   <= add2_next;
        end
    end

    assign q1_3_next = 13'(tt50_2_reg) * 13'(d2_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.adv[2])
        begin
            p3_reg    <= p2_reg;
            t3_reg    <= t2_reg;
            base3_reg <= base2_reg;
            lin3_reg  <= lin2_reg;
            add3_reg  <= add2_reg;
            q1_3_reg  <= q1_3_next;
        end
    end

    assign q2_4_next = 7'(cct_pkg::div50(q1_3_reg));

    always_ff @(posedge clk)
    begin
        if (ctl.adv[3])
        begin
            p4_reg    <= p3_reg;
            t4_reg    <= t3_reg;
            base4_reg <= base3_reg;
            lin4_reg  <= lin3_reg;
            add4_reg  <= add3_reg;
            q2_4_reg  <= q2_4_next;
        end
    end

    assign c3m_5_next = 13'(q2_4_reg) * 13'(t4_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.adv[4])
        begin
            p5_reg    <= p4_reg;
            base5_reg <= base4_reg;
            lin5_reg  <= lin4_reg;
            add5_reg  <= add4_reg;
            q2_5_reg  <= q2_4_reg;
            c3m_5_reg <= c3m_5_next;
        end
    end

    always_comb
    begin
        case (mode)
            cct_pkg::MODE_NONE:  comp6_next = 8'(p5_reg);
            cct_pkg::MODE_PCT:   comp6_next = 8'(base5_reg);
            cct_pkg::MODE_LIN:   comp6_next = 8'(base5_reg) + 8'(lin5_reg);
            cct_pkg::MODE_QUAD:  comp6_next = 8'(base5_reg) + 8'(q2_5_reg);
            cct_pkg::MODE_CUBIC: comp6_next = 8'(base5_reg) + cct_pkg::div50(c3m_5_reg);
            cct_pkg::MODE_TABLE: comp6_next = 8'(base5_reg) + 8'(add5_reg);
            default:             comp6_next = 8'(base5_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv[5])
            comp6_reg <= comp6_next;
    end

    // scale to timer ticks, clip at full scale and at the port width
    always_comb
    begin
        prod7 = PROD_W'(comp6_reg) * PROD_W'(SCALE);
        pulse7_next = (prod7 > PROD_W'(LIMIT)) ? 11'(LIMIT) : 11'(prod7);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv[6])
            pulse7_reg <= pulse7_next;
    end

    assign pulse_width = pulse7_reg;

endmodule

// File: rtl/cct_dimming_compensation.sv
// CCT dimming compensation top level: config registers, pipeline valid/stall
// control and two channel datapaths. Depends on cct_pkg, cct_comp_chan, macros header.
//
// Usage:
//   s_axis carries one word per request: cold and warm brightness percent.
//   m_axis returns one word per request: cold and warm PWM compare values.
//   cfg_wr_en/cfg_index/cfg_data write the mode and the two power caps; write
//   only while no word is in flight.
// Pipeline: an accepted word passes through the seven stage registers to m_axis_tvalid.
// Throughput: one word per cycle while m_axis_tready is high; each stage holds one word.
// Reset: clears all valid bits, holds s_axis_tready low and sets mode none,
//   both caps to 100 percent.
// Stall: when m_axis_tready is low the output word holds; stages behind it
//   keep filling empty slots, and s_axis_tready drops only once every stage
//   holds a word.
`include "cct_dimming_compensation_macros.svh"

module cct_dimming_compensation #(
    parameter int PULSE_FULL_SCALE = cct_pkg::PULSE_FULL_SCALE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] cold_percent, [15:8] warm_percent
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [10:0] cold_pulse_width, [21:11] warm_pulse_width
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    localparam int NSTAGE = cct_pkg::NSTAGE;
    localparam int LIMIT = (PULSE_FULL_SCALE < cct_pkg::OUT_MAX) ?
                           PULSE_FULL_SCALE : cct_pkg::OUT_MAX;
    localparam logic [10:0] PULSE_LIMIT = 11'(LIMIT);

    logic [2:0]         mode_reg;
    logic [6:0]         cold_watt_reg, warm_watt_reg;
    logic [NSTAGE-1:0]  v_reg, v_next;
    cct_pkg::pipe_ctl_t ctl;
    logic [10:0]        cold_pulse_width, warm_pulse_width;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= cct_pkg::MODE_NONE;
            cold_watt_reg <= 7'd100;
            warm_watt_reg <= 7'd100;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                cct_pkg::REG_MODE:      mode_reg <= cfg_data[2:0];
                cct_pkg::REG_COLD_WATT: cold_watt_reg <= cfg_data;
                cct_pkg::REG_WARM_WATT: warm_watt_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // a stage advances when empty or when the stage after it advances
    always_comb
    begin
        ctl.adv[NSTAGE-1] = !v_reg[NSTAGE-1] || m_axis_tready;
        for (int k = NSTAGE - 2; k >= 0; k--)
            ctl.adv[k] = !v_reg[k] || ctl.adv[k+1];
        v_next[0] = ctl.adv[0] ? s_axis_tvalid : v_reg[0];
        for (int k = 1; k < NSTAGE; k++)
            v_next[k] = ctl.adv[k] ? v_reg[k-1] : v_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    cct_comp_chan #(
        .PULSE_FULL_SCALE(PULSE_FULL_SCALE)
    ) u_cold (
        .clk         (clk),
        .ctl         (ctl),
        .mode        (mode_reg),
        .watt        (cold_watt_reg),
        .adds        (cct_pkg::COLD_ADD),
        .pct         (s_axis_tdata[7:0]),
        .pulse_width (cold_pulse_width)
    );

    cct_comp_chan #(
        .PULSE_FULL_SCALE(PULSE_FULL_SCALE)
    ) u_warm (
        .clk         (clk),
        .ctl         (ctl),
        .mode        (mode_reg),
        .watt        (warm_watt_reg),
        .adds        (cct_pkg::WARM_ADD),
        .pct         (s_axis_tdata[15:8]),
        .pulse_width (warm_pulse_width)
    );

    // take no word while reset is held
    assign s_axis_tready = ctl.adv[0] && rst_n;
    assign m_axis_tvalid = v_reg[NSTAGE-1];
    assign m_axis_tdata = {2'b00, warm_pulse_width, cold_pulse_width};

    `CCT_ASSERT_NXT(a_accept_fills_stage1, s_axis_tvalid && s_axis_tready, v_reg[0], "accepted word did not enter stage 1")
    `CCT_ASSERT_IMP(a_full_stall_blocks_input, ($countones(v_reg) == NSTAGE) && !m_axis_tready, !s_axis_tready, "input taken while pipeline full and stalled")
    `CCT_ASSERT_IMP(a_pulse_in_range, m_axis_tvalid, (m_axis_tdata[10:0] <= PULSE_LIMIT) && (m_axis_tdata[21:11] <= PULSE_LIMIT), "compare value above full scale")

endmodule
